>>> src/tilt_side_classifier_macros.svh
// assertion macros for the tilt side classifier
`ifndef TILT_SIDE_CLASSIFIER_MACROS_SVH
`define TILT_SIDE_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off while in reset
`define TSC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, off while in reset
`define TSC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSC_ASSERT_IMP(name, ante, cons, msg)
`define TSC_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

>>> src/tsc_pkg.sv
// shared types, constants and the arctangent table of the tilt side classifier
package tsc_pkg;

  // field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned DegW    = 9;
  localparam int unsigned FaceW   = 3;
  localparam int unsigned CalW    = 18;
  localparam int unsigned CfgIdxW = 3;

  // side checking
  localparam int unsigned NumCal     = 6;
  localparam int unsigned NumFaces   = 6;
  localparam int unsigned NumChecked = (NumFaces < NumCal) ? NumFaces : NumCal;

  // cordic sizing
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanTabLen  = 24;
  localparam int unsigned StepsRun    = (CordicSteps > AtanTabLen) ? AtanTabLen : CordicSteps;
  localparam int unsigned StepW       = $clog2(AtanTabLen);
  localparam int unsigned CenW        = 14;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned VecW        = 32;
  localparam int unsigned AngW        = 28;

  // degree conversion sizing
  localparam int unsigned ProdW    = 42;
  localparam int unsigned DivShift = 24;
  localparam int unsigned OffW     = 19;
  localparam int unsigned QuotW    = 16;
  localparam int unsigned MulOutW  = 33;

  // constants
  localparam logic [FaceW-1:0]       NoFace      = 3'd6;
  localparam logic [DegW-1:0]        ThreshReset = 9'd20;
  localparam logic [DegW-1:0]        DegMax      = 9'd360;
  localparam logic signed [CenW-1:0] OffXY       = 14'sd4095;
  localparam logic signed [CenW-1:0] OffZ        = 14'sd4467;
  localparam logic signed [AngW-1:0] HalfPiFx    = 28'sd26353589;
  // angle * 18000 / (314 * 2^24) reduced to angle * 9000 / (157 * 2^24)
  localparam logic signed [14:0]     DegScale    = 15'sd9000;
  // 180 degrees in units of 157 * 2^24 after the shift
  localparam logic signed [OffW-1:0] DegOffset   = 19'sd28260;
  // ceil(2^24 / 157), exact floor for any quotient input below 2^16
  localparam logic [16:0]            Recip157    = 17'd106862;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD,
    CFG_CAL_ZERO,
    CFG_CAL_ONE,
    CFG_CAL_TWO,
    CFG_CAL_THREE,
    CFG_CAL_FOUR,
    CFG_CAL_FIVE
  } tsc_cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_SCALE,
    ST_OFFSET,
    ST_DIVIDE,
    ST_OUTPUT
  } tsc_state_e;

  typedef struct packed {
    logic [SampleW-1:0] accel_x;
    logic [SampleW-1:0] accel_y;
    logic [SampleW-1:0] accel_z;
  } tsc_in_t;

  typedef struct packed {
    logic [FaceW-1:0] active_face;
    logic             face_changed;
    logic [DegW-1:0]  roll_deg;
    logic [DegW-1:0]  pitch_deg;
  } tsc_out_t;

  typedef struct packed {
    logic [DegW-1:0]             threshold;
    logic [NumCal-1:0][CalW-1:0] cal;
  } tsc_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic             sample_ld;
    logic             cordic_ld;
    logic             cordic_step;
    logic             which;
    logic [StepW-1:0] step;
    logic             conv_mul;
    logic             conv_off;
    logic             conv_div;
    logic             out_ld;
  } tsc_cmd_t;

  // atan(2^-i) * 2^24, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_entry(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] val;
    unique case (idx)
      5'd0:    val = 28'sd13176795;
      5'd1:    val = 28'sd7778716;
      5'd2:    val = 28'sd4110060;
      5'd3:    val = 28'sd2086331;
      5'd4:    val = 28'sd1047214;
      5'd5:    val = 28'sd524117;
      5'd6:    val = 28'sd262123;
      5'd7:    val = 28'sd131069;
      5'd8:    val = 28'sd65536;
      5'd9:    val = 28'sd32768;
      5'd10:   val = 28'sd16384;
      5'd11:   val = 28'sd8192;
      5'd12:   val = 28'sd4096;
      5'd13:   val = 28'sd2048;
      5'd14:   val = 28'sd1024;
      5'd15:   val = 28'sd512;
      5'd16:   val = 28'sd256;
      5'd17:   val = 28'sd128;
      5'd18:   val = 28'sd64;
      5'd19:   val = 28'sd32;
      5'd20:   val = 28'sd16;
      5'd21:   val = 28'sd8;
      5'd22:   val = 28'sd4;
      5'd23:   val = 28'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> src/tsc_cfg_regs.sv
// configuration register file: match threshold and six calibrated sides
module tsc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [tsc_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [tsc_pkg::CalW-1:0]     wr_data_i,
  output tsc_pkg::tsc_cfg_t            cfg_o
);
  import tsc_pkg::*;

  logic [DegW-1:0]             threshold_q;
  logic [NumCal-1:0][CalW-1:0] cal_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThreshReset;
      cal_q       <= '0;
    end else if (wr_en_i) begin
      unique case (tsc_cfg_idx_e'(wr_index_i))
        CFG_THRESHOLD:  threshold_q <= wr_data_i[DegW-1:0];
        CFG_CAL_ZERO:   cal_q[0]    <= wr_data_i;
        CFG_CAL_ONE:    cal_q[1]    <= wr_data_i;
        CFG_CAL_TWO:    cal_q[2]    <= wr_data_i;
        CFG_CAL_THREE:  cal_q[3]    <= wr_data_i;
        CFG_CAL_FOUR:   cal_q[4]    <= wr_data_i;
        CFG_CAL_FIVE:   cal_q[5]    <= wr_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.threshold = threshold_q;
  assign cfg_o.cal       = cal_q;

endmodule

>>> src/tsc_ctrl.sv
// sequencing controller: two cordic passes, degree conversion, result transfer
module tsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tsc_pkg::tsc_cmd_t cmd_o
);
  import tsc_pkg::*;

  tsc_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             which_q, which_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // next state and counters
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    which_d = which_q;
    unique case (state_q)
      ST_IDLE: begin
        which_d = 1'b0;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        step_d  = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (step_q == StepW'(StepsRun - 1)) begin
          state_d = ST_SCALE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_SCALE:  state_d = ST_OFFSET;
      ST_OFFSET: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (which_q) begin
          state_d = ST_OUTPUT;
        end else begin
          which_d = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_OUTPUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands and handshake outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.step        = step_q;
    cmd_o.which       = which_q;
    in_stall_o        = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.sample_ld = in_valid_i;
      end
      ST_LOAD:   cmd_o.cordic_ld   = 1'b1;
      ST_ITER:   cmd_o.cordic_step = 1'b1;
      ST_SCALE:  cmd_o.conv_mul    = 1'b1;
      ST_OFFSET: cmd_o.conv_off    = 1'b1;
      ST_DIVIDE: cmd_o.conv_div    = 1'b1;
      ST_OUTPUT: cmd_o.out_ld      = out_free;
      default: begin
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      which_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      which_q     <= which_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/tsc_datapath.sv
// datapath: sample centring, shared cordic, degree conversion, side match
module tsc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsc_pkg::tsc_cmd_t cmd_i,
  input  tsc_pkg::tsc_in_t  in_data_i,
  input  tsc_pkg::tsc_cfg_t cfg_i,
  output tsc_pkg::tsc_out_t out_data_o
);
  import tsc_pkg::*;

  logic signed [CenW-1:0]  xs_q, ys_q, zs_q;
  logic signed [CenW-1:0]  xs_d, ys_d, zs_d;
  logic signed [CenW-1:0]  a_op, b_op;
  logic signed [VecW-1:0]  va, vb, dx, dy;
  logic signed [VecW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0]  ang_q, ang_d, atan_val;
  logic signed [ProdW-1:0] p_q, p_d;
  logic signed [OffW-1:0]  m_full;
  logic [QuotW-1:0]        m_q, m_d;
  logic [MulOutW-1:0]      qprod;
  logic [DegW-1:0]         deg_raw, deg;
  logic [DegW-1:0]         roll_q, pitch_q;
  logic [FaceW-1:0]        face_q, face_sel;
  tsc_out_t                out_q;

  // centre the sample in half-lsb units
  assign xs_d = $signed({1'b0, in_data_i.accel_x, 1'b0}) - OffXY;
  assign ys_d = $signed({1'b0, in_data_i.accel_y, 1'b0}) - OffXY;
  assign zs_d = $signed({1'b0, in_data_i.accel_z, 1'b0}) - OffZ;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_ld) begin
      xs_q <= xs_d;
      ys_q <= ys_d;
      zs_q <= zs_d;
    end
  end

  // operand pick: roll is atan2(y, z), pitch is atan2(z, x)
  always_comb begin
    a_op = cmd_i.which ? zs_q : ys_q;
    b_op = cmd_i.which ? xs_q : zs_q;
    va   = VecW'(a_op) <<< FracBits;
    vb   = VecW'(b_op) <<< FracBits;
  end

  // cordic vectoring: quarter-turn pre-rotation, then one micro-rotation a cycle
  // centred operands are odd, so both being zero never happens
  assign dx       = y_q >>> cmd_i.step;
  assign dy       = x_q >>> cmd_i.step;
  assign atan_val = atan_entry(cmd_i.step);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    ang_d = ang_q;
    if (cmd_i.cordic_ld) begin
      if (vb < 0) begin
        if (va >= 0) begin
          x_d   = va;
          y_d   = -vb;
          ang_d = HalfPiFx;
        end else begin
          x_d   = -va;
          y_d   = vb;
          ang_d = -HalfPiFx;
        end
      end else begin
        x_d   = vb;
        y_d   = va;
        ang_d = '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (y_q > 0) begin
        x_d   = x_q + dx;
        y_d   = y_q - dy;
        ang_d = ang_q + atan_val;
      end else begin
        x_d   = x_q - dx;
        y_d   = y_q + dy;
        ang_d = ang_q - atan_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
  end

  // degree conversion, stage one: scale the angle
  assign p_d = ProdW'(ang_q) * ProdW'(DegScale);

  // stage two: drop 24 fraction bits, add the 180 degree offset, clip below zero
  assign m_full = OffW'(p_q >>> DivShift) + DegOffset;
  assign m_d    = m_full[OffW-1] ? '0 : m_full[QuotW-1:0];

  // stage three: divide by 157 with a reciprocal multiply, clip at 360
  assign qprod   = MulOutW'(m_q) * MulOutW'(Recip157);
  assign deg_raw = qprod[DivShift +: DegW];
  assign deg     = (deg_raw > DegMax) ? DegMax : deg_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_mul) begin
      p_q <= p_d;
    end
    if (cmd_i.conv_off) begin
      m_q <= m_d;
    end
    if (cmd_i.conv_div) begin
      if (cmd_i.which) begin
        pitch_q <= deg;
      end else begin
        roll_q <= deg;
      end
    end
  end

  // window match over the calibrated sides, the last match wins
  always_comb begin
    logic [DegW:0] cr, cp, thr, roll_e, pitch_e;
    face_sel = face_q;
    thr      = {1'b0, cfg_i.threshold};
    roll_e   = {1'b0, roll_q};
    pitch_e  = {1'b0, pitch_q};
    cr       = '0;
    cp       = '0;
    for (int i = 0; i < NumChecked; i++) begin
      cp = {1'b0, cfg_i.cal[i][DegW-1:0]};
      cr = {1'b0, cfg_i.cal[i][CalW-1:DegW]};
      if ((roll_e + thr > cr) && (roll_e < cr + thr) &&
          (pitch_e + thr > cp) && (pitch_e < cp + thr)) begin
        face_sel = FaceW'(i);
      end
    end
  end

  // held side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q <= NoFace;
    end else if (cmd_i.out_ld) begin
      face_q <= face_sel;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.active_face  <= face_sel;
      out_q.face_changed <= (face_sel != face_q);
      out_q.roll_deg     <= roll_q;
      out_q.pitch_deg    <= pitch_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/tilt_side_classifier.sv
// top level of the tilt side classifier
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i / in_stall_o    in_data_i  (x, y, z samples)
//  out       source     out_valid_o / out_stall_i  out_data_o (side, changed, roll, pitch)
//  cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one sample at a time: the shared cordic runs roll then pitch, each pass running
// load, the micro-rotation steps and three conversion stages; the result is then
// loaded into the output register, which raises out_valid_o
// rst_ni resets the controller, the held side (no side yet) and the config registers
// a finished result sits in the output register; the next sample is taken while it
// waits, and only the final result load waits on out_stall_i
// cfg_ready_o is always high
`include "tilt_side_classifier_macros.svh"

module tilt_side_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tsc_pkg::tsc_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tsc_pkg::tsc_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tsc_pkg::CalW-1:0]    cfg_data_i
);
  import tsc_pkg::*;

  tsc_cmd_t cmd;
  tsc_cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  tsc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tsc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .out_data_o (out_data_o)
  );

  // a sample transfer starts a computation, so the input stalls next cycle
  `TSC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled while busy")
  // reported side is a calibrated side or the no-side code
  `TSC_ASSERT_IMP(a_face_range, out_valid_o, out_data_o.active_face <= NoFace, "side index out of range")
  // the no-side code can only persist, never be entered by a change
  `TSC_ASSERT_IMP(a_no_face_unchanged, out_valid_o && out_data_o.active_face == NoFace, !out_data_o.face_changed, "change flagged without a side")
  // both angles stay inside 0..360
  `TSC_ASSERT_IMP(a_angle_range, out_valid_o, out_data_o.roll_deg <= DegMax && out_data_o.pitch_deg <= DegMax, "angle above 360")

endmodule
